[design/scr_pkg.sv]
// Package for the sprite corner rotation block: widths, constants, item types,
// register indexes and the small arithmetic helpers shared by the pipeline modules.
// Depends on nothing; every other design file imports it.
`default_nettype none

package scr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int ANGLE_W     = 16;
  localparam int OFFSET_W    = 16;
  localparam int SIZE_W      = 12;
  localparam int ANCHOR_W    = 16;
  localparam int ORIGIN_W    = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_X      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_Y      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd5;

  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 12'd64;
  localparam logic [ANCHOR_W-1:0] ANCHOR_RESET = 16'd32768;

  localparam logic [ANGLE_W-1:0] ANG_QUAD = 16'd11520;
  localparam logic [ANGLE_W-1:0] ANG_HALF = 16'd23040;
  localparam logic [ANGLE_W-1:0] ANG_3Q   = 16'd34560;
  localparam logic [ANGLE_W-1:0] ANG_FULL = 16'd46080;
  localparam int REM_W = 14;

  localparam int SINE_LAT = 15;
  localparam int SINE_W   = 16;
  localparam int X_W      = 31;
  localparam int U_W      = 32;
  localparam int T_W      = 31;
  localparam logic [31:0] RAD_PER_STEP_Q30 = 32'd146409;
  localparam logic [31:0] ONE_Q30          = 32'h4000_0000;
  localparam logic [SINE_W:0] SINE_MAX     = 17'd32768;

  localparam logic [7:0] DIV_72 = 8'd72;
  localparam logic [7:0] DIV_42 = 8'd42;
  localparam logic [7:0] DIV_20 = 8'd20;
  localparam logic [7:0] DIV_6  = 8'd6;
  localparam logic [31:0] RECIP_72 = 32'(64'h1_0000_0000 / 64'd72);
  localparam logic [31:0] RECIP_42 = 32'(64'h1_0000_0000 / 64'd42);
  localparam logic [31:0] RECIP_20 = 32'(64'h1_0000_0000 / 64'd20);
  localparam logic [31:0] RECIP_6  = 32'(64'h1_0000_0000 / 64'd6);

  localparam int VEC_W  = 30;
  localparam int TRIG_W = 17;
  localparam int PROD_W = VEC_W + TRIG_W;
  localparam int SUM_W  = 50;
  localparam int QUO_W  = SUM_W - 31;
  localparam int EXT_W  = ((QUO_W > COORD_BITS) ? QUO_W : COORD_BITS) + 1;
  localparam logic signed [EXT_W-1:0] COORD_HI =
    EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] COORD_LO =
    EXT_W'(-(64'sd1 <<< (COORD_BITS - 1)));

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    quad_t                       quad;
    logic signed [OFFSET_W-1:0]  offset_x;
    logic signed [OFFSET_W-1:0]  offset_y;
  } side_t;

  typedef struct packed {
    logic [SIZE_W-1:0]          sprite_width;
    logic [SIZE_W-1:0]          sprite_height;
    logic [ANCHOR_W-1:0]        anchor_x;
    logic [ANCHOR_W-1:0]        anchor_y;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ul_x;
    logic signed [COORD_BITS-1:0] ul_y;
    logic signed [COORD_BITS-1:0] ur_x;
    logic signed [COORD_BITS-1:0] ur_y;
    logic signed [COORD_BITS-1:0] ll_x;
    logic signed [COORD_BITS-1:0] ll_y;
    logic signed [COORD_BITS-1:0] lr_x;
    logic signed [COORD_BITS-1:0] lr_y;
  } corners_t;

  // The estimate q0 from the reciprocal product is the true quotient or one below it.
  function automatic logic [31:0] div_fix(input logic [31:0] n, input logic [31:0] q0,
                                          input logic [7:0] d);
    logic [31:0] rem;
    rem = n - q0 * 32'(d);
    return (rem >= 32'(d)) ? q0 + 32'd1 : q0;
  endfunction

  // Divide by 2^31 toward zero, then clamp to the signed coordinate range.
  function automatic logic signed [COORD_BITS-1:0] trunc_sat(input logic signed [SUM_W-1:0] v);
    logic signed [QUO_W-1:0] q;
    logic signed [EXT_W-1:0] qe;
    q = QUO_W'(v >>> 31);
    if (v[SUM_W-1] && (v[30:0] != 31'd0)) begin
      q = q + QUO_W'(1);
    end
    qe = EXT_W'(q);
    if (qe > COORD_HI) begin
      qe = COORD_HI;
    end else if (qe < COORD_LO) begin
      qe = COORD_LO;
    end
    return COORD_BITS'(qe);
  endfunction

endpackage

`default_nettype wire

[design/scr_if.sv]
// Channel interfaces of the sprite corner rotation block: request, result
// and configuration write. Each carries valid, ready and its payload; uses scr_pkg.
`default_nettype none

interface scr_req_if import scr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ANGLE_W-1:0]         angle;
  logic signed [OFFSET_W-1:0] offset_x;
  logic signed [OFFSET_W-1:0] offset_y;
  modport source (output valid, angle, offset_x, offset_y, input ready);
  modport sink (input valid, angle, offset_x, offset_y, output ready);
endinterface

interface scr_rsp_if import scr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ul_x;
  logic signed [COORD_BITS-1:0] ul_y;
  logic signed [COORD_BITS-1:0] ur_x;
  logic signed [COORD_BITS-1:0] ur_y;
  logic signed [COORD_BITS-1:0] ll_x;
  logic signed [COORD_BITS-1:0] ll_y;
  logic signed [COORD_BITS-1:0] lr_x;
  logic signed [COORD_BITS-1:0] lr_y;
  modport source (output valid, ul_x, ul_y, ur_x, ur_y, ll_x, ll_y, lr_x, lr_y,
                  input ready);
  modport sink (input valid, ul_x, ul_y, ur_x, ur_y, ll_x, ll_y, lr_x, lr_y,
                output ready);
endinterface

interface scr_cfg_if import scr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/sprite_corner_rotation.sv]
// Top level of the sprite corner rotation block: configuration registers,
// angle stage, sine and cosine pipelines, corner stages and result buffer.
// Uses scr_pkg, the channel interfaces and all scr_* modules.
//
// Usage:
// Configuration writes arrive on cfg (index, data); register i of the list
// sprite_width, sprite_height, anchor_x, anchor_y, origin_x, origin_y has
// index i, and higher indexes are ignored. cfg is always ready. Write the
// registers only while no item is in flight.
// Each item on req (angle, offset_x, offset_y) gives exactly one item on rsp
// with the four rotated corners ul, ur, ll, lr as x/y pairs.
// Throughput is one item per clock unless rsp stalls with a full buffer.
// Each item passes one angle stage, the 15-stage sine/cosine pipeline
// and four corner stages, then the result buffer.
// A two-entry buffer holds results while rsp is stalled; the pipeline keeps
// moving until that buffer is full and is not being drained, and only then
// does req.ready drop. Nothing in flight is lost or repeated.
// Synchronous reset empties the pipeline and the buffer and loads the
// register defaults: size 64 x 64, anchors one half, origin zero.
`default_nettype none

module sprite_corner_rotation import scr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  scr_cfg_if.sink   cfg,
  scr_req_if.sink   req,
  scr_rsp_if.source rsp
);

  cfg_t              cfg_q;
  logic              advance;
  logic              ang_valid;
  side_t             ang_side;
  logic [REM_W-1:0]  ang_rem;
  logic [REM_W-1:0]  ang_rem_c;
  logic [SINE_W-1:0] sr;
  logic [SINE_W-1:0] cr;
  logic              v_d [SINE_LAT];
  side_t             side_d [SINE_LAT];
  logic              cor_valid;
  corners_t          cor;

  assign cfg.ready = 1'b1;
  assign req.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.sprite_width  <= SIZE_RESET;
      cfg_q.sprite_height <= SIZE_RESET;
      cfg_q.anchor_x      <= ANCHOR_RESET;
      cfg_q.anchor_y      <= ANCHOR_RESET;
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SPRITE_WIDTH: begin
          cfg_q.sprite_width <= cfg.data[SIZE_W-1:0];
        end
        REG_SPRITE_HEIGHT: begin
          cfg_q.sprite_height <= cfg.data[SIZE_W-1:0];
        end
        REG_ANCHOR_X: begin
          cfg_q.anchor_x <= cfg.data[ANCHOR_W-1:0];
        end
        REG_ANCHOR_Y: begin
          cfg_q.anchor_y <= cfg.data[ANCHOR_W-1:0];
        end
        REG_ORIGIN_X: begin
          cfg_q.origin_x <= signed'(cfg.data[ORIGIN_W-1:0]);
        end
        REG_ORIGIN_Y: begin
          cfg_q.origin_y <= signed'(cfg.data[ORIGIN_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  scr_angle u_angle (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (req.valid),
    .angle    (req.angle),
    .offset_x (req.offset_x),
    .offset_y (req.offset_y),
    .valid    (ang_valid),
    .side     (ang_side),
    .rem      (ang_rem),
    .rem_c    (ang_rem_c)
  );

  scr_sine u_sin (
    .clk  (clk),
    .en   (advance),
    .r    (ang_rem),
    .sine (sr)
  );

  scr_sine u_cos (
    .clk  (clk),
    .en   (advance),
    .r    (ang_rem_c),
    .sine (cr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SINE_LAT; k++) begin
        v_d[k] <= 1'b0;
      end
    end else if (advance) begin
      v_d[0] <= ang_valid;
      for (int k = 1; k < SINE_LAT; k++) begin
        v_d[k] <= v_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side_d[0] <= ang_side;
      for (int k = 1; k < SINE_LAT; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  scr_corner u_corner (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .cfg       (cfg_q),
    .in_valid  (v_d[SINE_LAT-1]),
    .side      (side_d[SINE_LAT-1]),
    .sr        (sr),
    .cr        (cr),
    .out_valid (cor_valid),
    .cor       (cor)
  );

  scr_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cor_valid),
    .in_cor   (cor),
    .advance  (advance),
    .rsp      (rsp)
  );

  a_wrap_to_zero: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.angle >= ANG_FULL))
      |=> (ang_rem == '0 && ang_side.quad == QUAD_0))
    else $error("angle of a full turn or more was not folded to zero");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cor_valid && advance))
    else $error("result appeared without an item leaving the corner stages");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("request stalled while the result buffer is empty");

endmodule

`default_nettype wire

[design/scr_angle.sv]
// First pipeline stage: folds the angle into a quadrant and a remainder,
// and the complementary remainder used for the cosine. Uses scr_pkg.
`default_nettype none

module scr_angle import scr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ANGLE_W-1:0]         angle,
  input  logic signed [OFFSET_W-1:0] offset_x,
  input  logic signed [OFFSET_W-1:0] offset_y,
  output logic                       valid,
  output side_t                      side,
  output logic [REM_W-1:0]           rem,
  output logic [REM_W-1:0]           rem_c
);

  logic [ANGLE_W-1:0] a;
  quad_t              quad_next;
  logic [REM_W-1:0]   rem_next;

  always_comb begin
    a = (angle >= ANG_FULL) ? '0 : angle;
    if (a < ANG_QUAD) begin
      quad_next = QUAD_0;
      rem_next  = REM_W'(a);
    end else if (a < ANG_HALF) begin
      quad_next = QUAD_1;
      rem_next  = REM_W'(a - ANG_QUAD);
    end else if (a < ANG_3Q) begin
      quad_next = QUAD_2;
      rem_next  = REM_W'(a - ANG_HALF);
    end else begin
      quad_next = QUAD_3;
      rem_next  = REM_W'(a - ANG_3Q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.quad     <= quad_next;
      side.offset_x <= offset_x;
      side.offset_y <= offset_y;
      rem           <= rem_next;
      rem_c         <= REM_W'(ANG_QUAD - ANGLE_W'(rem_next));
    end
  end

endmodule

`default_nettype wire

[design/scr_sine.sv]
// Fifteen-stage quarter-wave sine pipeline: Horner evaluation of the Taylor
// series with reciprocal-multiply constant divides. Uses scr_pkg.
`default_nettype none

module scr_sine import scr_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [REM_W-1:0]  r,
  output logic [SINE_W-1:0] sine
);

  logic [X_W-1:0] x_q [1:13];
  logic [U_W-1:0] u_q [2:10];
  logic [31:0]    quo_3, quo_6, quo_9, quo_12;
  logic [31:0]    p_5, p_6, p_8, p_9, p_11, p_12;
  logic [T_W-1:0] t_4, t_7, t_10, t_13;
  logic [30:0]    s_14;

  logic [31:0] x_prod;
  logic [61:0] sq_2;
  logic [63:0] rp_3, rp_6, rp_9, rp_12;
  logic [62:0] up_5, up_8, up_11;
  logic [61:0] sp_14;
  logic [31:0] rnd_15;

  assign x_prod = 32'(r) * RAD_PER_STEP_Q30;
  assign sq_2   = 62'(x_q[1]) * 62'(x_q[1]);
  assign rp_3   = 64'(u_q[2]) * 64'(RECIP_72);
  assign up_5   = 63'(u_q[4]) * 63'(t_4);
  assign rp_6   = 64'(p_5) * 64'(RECIP_42);
  assign up_8   = 63'(u_q[7]) * 63'(t_7);
  assign rp_9   = 64'(p_8) * 64'(RECIP_20);
  assign up_11  = 63'(u_q[10]) * 63'(t_10);
  assign rp_12  = 64'(p_11) * 64'(RECIP_6);
  assign sp_14  = 62'(x_q[13]) * 62'(t_13);
  assign rnd_15 = 32'(s_14) + 32'd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[1] <= X_W'(x_prod);
      for (int k = 2; k <= 13; k++) begin
        x_q[k] <= x_q[k-1];
      end
      u_q[2] <= sq_2[61:30];
      for (int k = 3; k <= 10; k++) begin
        u_q[k] <= u_q[k-1];
      end
      quo_3  <= rp_3[63:32];
      t_4    <= T_W'(ONE_Q30 - div_fix(u_q[3], quo_3, DIV_72));
      p_5    <= up_5[61:30];
      quo_6  <= rp_6[63:32];
      p_6    <= p_5;
      t_7    <= T_W'(ONE_Q30 - div_fix(p_6, quo_6, DIV_42));
      p_8    <= up_8[61:30];
      quo_9  <= rp_9[63:32];
      p_9    <= p_8;
      t_10   <= T_W'(ONE_Q30 - div_fix(p_9, quo_9, DIV_20));
      p_11   <= up_11[61:30];
      quo_12 <= rp_12[63:32];
      p_12   <= p_11;
      t_13   <= T_W'(ONE_Q30 - div_fix(p_12, quo_12, DIV_6));
      s_14   <= sp_14[60:30];
      sine   <= (rnd_15[31:15] > SINE_MAX) ? SINE_W'(SINE_MAX) : rnd_15[30:15];
    end
  end

endmodule

`default_nettype wire

[design/scr_corner.sv]
// Corner stages: quadrant mapping of sine and cosine, the eight rotation
// products, the sums with origin and offset, then truncation and clamping.
// Uses scr_pkg; the corner vectors are refreshed from the registers every cycle.
`default_nettype none

module scr_corner import scr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  side_t             side,
  input  logic [SINE_W-1:0] sr,
  input  logic [SINE_W-1:0] cr,
  output logic              out_valid,
  output corners_t          cor
);

  logic signed [VEC_W-1:0] left, right, top, bottom;
  logic [VEC_W-1:0]        wa, wb, ha, hb;

  logic                     v0, v1, v2;
  side_t                    side0;
  logic signed [TRIG_W-1:0] s0, c0;
  logic signed [TRIG_W-1:0] s_next, c_next;
  logic signed [TRIG_W-1:0] srs, crs;

  logic signed [PROD_W-1:0] lc, rc, ts, bs, ls, rs, tc, bc;
  logic signed [SUM_W-1:0]  base_x, base_y;
  logic signed [SUM_W-1:0]  ul_x, ul_y, ur_x, ur_y, ll_x, ll_y, lr_x, lr_y;

  assign wa = VEC_W'(cfg.sprite_width) * VEC_W'(cfg.anchor_x);
  assign wb = VEC_W'(cfg.sprite_width) * (VEC_W'(17'h1_0000) - VEC_W'(cfg.anchor_x));
  assign ha = VEC_W'(cfg.sprite_height) * VEC_W'(cfg.anchor_y);
  assign hb = VEC_W'(cfg.sprite_height) * (VEC_W'(17'h1_0000) - VEC_W'(cfg.anchor_y));

  always_ff @(posedge clk) begin
    left   <= -signed'(wa);
    right  <= signed'(wb);
    top    <= -signed'(ha);
    bottom <= signed'(hb);
  end

  assign srs = signed'({1'b0, sr});
  assign crs = signed'({1'b0, cr});

  always_comb begin
    case (side.quad)
      QUAD_0: begin
        s_next = srs;
        c_next = crs;
      end
      QUAD_1: begin
        s_next = crs;
        c_next = -srs;
      end
      QUAD_2: begin
        s_next = -srs;
        c_next = -crs;
      end
      default: begin
        s_next = -crs;
        c_next = srs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0  <= side;
      s0     <= s_next;
      c0     <= c_next;

      lc     <= PROD_W'(left) * PROD_W'(c0);
      rc     <= PROD_W'(right) * PROD_W'(c0);
      ts     <= PROD_W'(top) * PROD_W'(s0);
      bs     <= PROD_W'(bottom) * PROD_W'(s0);
      ls     <= PROD_W'(left) * PROD_W'(s0);
      rs     <= PROD_W'(right) * PROD_W'(s0);
      tc     <= PROD_W'(top) * PROD_W'(c0);
      bc     <= PROD_W'(bottom) * PROD_W'(c0);
      base_x <= (SUM_W'(signed'(cfg.origin_x)) <<< 27)
              + (SUM_W'(signed'(side0.offset_x)) <<< 31);
      base_y <= (SUM_W'(signed'(cfg.origin_y)) <<< 27)
              + (SUM_W'(signed'(side0.offset_y)) <<< 31);

      ul_x   <= SUM_W'(lc) - SUM_W'(ts) + base_x;
      ul_y   <= SUM_W'(ls) + SUM_W'(tc) + base_y;
      ur_x   <= SUM_W'(rc) - SUM_W'(ts) + base_x;
      ur_y   <= SUM_W'(rs) + SUM_W'(tc) + base_y;
      ll_x   <= SUM_W'(lc) - SUM_W'(bs) + base_x;
      ll_y   <= SUM_W'(ls) + SUM_W'(bc) + base_y;
      lr_x   <= SUM_W'(rc) - SUM_W'(bs) + base_x;
      lr_y   <= SUM_W'(rs) + SUM_W'(bc) + base_y;

      cor.ul_x <= trunc_sat(ul_x);
      cor.ul_y <= trunc_sat(ul_y);
      cor.ur_x <= trunc_sat(ur_x);
      cor.ur_y <= trunc_sat(ur_y);
      cor.ll_x <= trunc_sat(ll_x);
      cor.ll_y <= trunc_sat(ll_y);
      cor.lr_x <= trunc_sat(lr_x);
      cor.lr_y <= trunc_sat(lr_y);
    end
  end

endmodule

`default_nettype wire

[design/scr_outbuf.sv]
// Two-entry result buffer between the pipeline and the result channel. It
// drives the pipeline advance enable. Uses scr_pkg and the result interface.
`default_nettype none

module scr_outbuf import scr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  corners_t  in_cor,
  output logic      advance,
  scr_rsp_if.source rsp
);

  corners_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  corners_t   head;

  assign advance   = (count != 2'd2) || rsp.ready;
  assign push      = advance && in_valid;
  assign pop       = rsp.valid && rsp.ready;
  assign rsp.valid = (count != 2'd0);
  assign head      = mem[rd_ptr];

  assign rsp.ul_x = head.ul_x;
  assign rsp.ul_y = head.ul_y;
  assign rsp.ur_x = head.ur_x;
  assign rsp.ur_y = head.ur_y;
  assign rsp.ll_x = head.ll_x;
  assign rsp.ll_y = head.ll_y;
  assign rsp.lr_x = head.lr_x;
  assign rsp.lr_y = head.lr_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cor;
    end
  end

endmodule

`default_nettype wire

[dv/tb_sprite_corner_rotation.sv]
`timescale 1ns / 100ps
// Testbench for sprite_corner_rotation: sends angle and offset items with random idling on
// both channels and checks all four rotated corners against an in-bench fixed-point predictor.
// Depends on scr_pkg, the scr_*_if channel interfaces and the design files.

module tb_sprite_corner_rotation;
  import scr_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 110;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [ANGLE_W-1:0]     ANG_EIGHTH  = ANG_QUAD / 2;

  localparam longint unsigned PHASE_ONE_Q30 = 64'd1 << 30;
  localparam longint ANCHOR_ONE   = 64'sd65536;
  localparam longint ORIGIN_SCALE = 64'sd1 <<< 27;
  localparam longint OFFSET_SCALE = 64'sd1 <<< 31;
  localparam longint COORD_MAX    = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam longint COORD_MIN    = -COORD_MAX - 64'sd1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  scr_cfg_if cfg_ch ();
  scr_req_if req_ch ();
  scr_rsp_if rsp_ch ();

  sprite_corner_rotation u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [SIZE_W-1:0]          cur_width    = SIZE_RESET;
  logic [SIZE_W-1:0]          cur_height   = SIZE_RESET;
  logic [ANCHOR_W-1:0]        cur_anchor_x = ANCHOR_RESET;
  logic [ANCHOR_W-1:0]        cur_anchor_y = ANCHOR_RESET;
  logic signed [ORIGIN_W-1:0] cur_origin_x = '0;
  logic signed [ORIGIN_W-1:0] cur_origin_y = '0;

  corners_t expected_corners[$];
  string    field_names[8] = '{"ul_x", "ul_y", "ur_x", "ur_y", "ll_x", "ll_y", "lr_x", "lr_y"};
  int       error_count  = 0;
  int       stall_cycles = 0;
  bit       req_steady   = 1'b0;
  bit       rsp_steady   = 1'b0;

  function automatic longint quarter_sine_q15(input int unsigned r);
    longint unsigned x, u, t, s, q;
    x = longint'(r) * longint'(RAD_PER_STEP_Q30);
    u = (x * x) >> 30;
    t = PHASE_ONE_Q30 - u / 72;
    t = PHASE_ONE_Q30 - ((u * t) >> 30) / 42;
    t = PHASE_ONE_Q30 - ((u * t) >> 30) / 20;
    t = PHASE_ONE_Q30 - ((u * t) >> 30) / 6;
    s = (x * t) >> 30;
    q = (s + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return longint'(q);
  endfunction

  function automatic logic [COORD_BITS-1:0] coord_of(input longint v);
    longint q;
    q = v / OFFSET_SCALE;
    if (q > COORD_MAX) begin
      q = COORD_MAX;
    end else if (q < COORD_MIN) begin
      q = COORD_MIN;
    end
    return q[COORD_BITS-1:0];
  endfunction

  function automatic corners_t predict_corners(input logic [ANGLE_W-1:0] angle,
                                               input logic signed [OFFSET_W-1:0] off_x,
                                               input logic signed [OFFSET_W-1:0] off_y);
    logic [ANGLE_W-1:0] a;
    quad_t quad;
    int unsigned r;
    longint sr, cr, s, c, left, right, top, bottom, base_x, base_y;
    longint vx[4], vy[4];
    logic [7:0][COORD_BITS-1:0] flat;
    a = (angle >= ANG_FULL) ? '0 : angle;
    quad = quad_t'(2'(a / ANG_QUAD));
    r = a % ANG_QUAD;
    sr = quarter_sine_q15(r);
    cr = quarter_sine_q15(ANG_QUAD - r);
    case (quad)
      QUAD_0: begin
        s = sr;
        c = cr;
      end
      QUAD_1: begin
        s = cr;
        c = -sr;
      end
      QUAD_2: begin
        s = -sr;
        c = -cr;
      end
      default: begin
        s = -cr;
        c = sr;
      end
    endcase
    left   = -(longint'(cur_width) * longint'(cur_anchor_x));
    right  = longint'(cur_width) * (ANCHOR_ONE - longint'(cur_anchor_x));
    top    = -(longint'(cur_height) * longint'(cur_anchor_y));
    bottom = longint'(cur_height) * (ANCHOR_ONE - longint'(cur_anchor_y));
    base_x = longint'(cur_origin_x) * ORIGIN_SCALE + longint'(off_x) * OFFSET_SCALE;
    base_y = longint'(cur_origin_y) * ORIGIN_SCALE + longint'(off_y) * OFFSET_SCALE;
    vx = '{left, right, left, right};
    vy = '{top, top, bottom, bottom};
    for (int i = 0; i < 4; i++) begin
      flat[7 - 2 * i] = coord_of(vx[i] * c - vy[i] * s + base_x);
      flat[6 - 2 * i] = coord_of(vx[i] * s + vy[i] * c + base_y);
    end
    return corners_t'(flat);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_SPRITE_WIDTH:  cur_width    = data[SIZE_W-1:0];
      REG_SPRITE_HEIGHT: cur_height   = data[SIZE_W-1:0];
      REG_ANCHOR_X:      cur_anchor_x = data[ANCHOR_W-1:0];
      REG_ANCHOR_Y:      cur_anchor_y = data[ANCHOR_W-1:0];
      REG_ORIGIN_X:      cur_origin_x = data[ORIGIN_W-1:0];
      REG_ORIGIN_Y:      cur_origin_y = data[ORIGIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Must be called straight after the previous item was accepted, so that valid never
  // stays high across an edge by accident.
  task automatic send_item(input logic [ANGLE_W-1:0] angle,
                           input logic signed [OFFSET_W-1:0] off_x,
                           input logic signed [OFFSET_W-1:0] off_y);
    int gap;
    gap = req_steady ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.angle    <= angle;
    req_ch.offset_x <= off_x;
    req_ch.offset_y <= off_y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_corners.push_back(predict_corners(angle, off_x, off_y));
  endtask

  task automatic drain_results;
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_corners.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_defaults;
    send_item('0, '0, '0);
    send_item(ANG_EIGHTH, 16'sd100, -16'sd100);
    send_item(ANG_QUAD - 16'd1, 16'sh7FFF, 16'sh7FFF);
    send_item(ANG_QUAD, 16'sh8000, 16'sh8000);
    send_item(ANG_QUAD + 16'd1, 16'sd1, -16'sd1);
    send_item(ANG_HALF, 16'sh8000, 16'sh7FFF);
    send_item(ANG_3Q, 16'sh7FFF, 16'sh8000);
    send_item(ANG_FULL - 16'd1, '0, '0);
    send_item(ANG_FULL, 16'sd5, 16'sd5);
    send_item(16'hFFFF, -16'sd5, 16'sd7);
    send_item(16'd1, 16'sh5555, 16'shAAAA);
    drain_results();
  endtask

  task automatic test_register_extremes;
    write_reg(REG_SPRITE_WIDTH, 20'hFFFFF);
    write_reg(REG_SPRITE_HEIGHT, 20'h00FFF);
    write_reg(REG_ANCHOR_X, '0);
    write_reg(REG_ANCHOR_Y, '0);
    write_reg(REG_ORIGIN_X, 20'h7FFFF);
    write_reg(REG_ORIGIN_Y, 20'h7FFFF);
    send_item(ANG_EIGHTH, 16'sh7FFF, 16'sh7FFF);
    send_item(ANG_HALF, 16'sh8000, 16'sh8000);
    drain_results();

    write_reg(REG_ANCHOR_X, 20'h0FFFF);
    write_reg(REG_ANCHOR_Y, 20'hFFFFF);
    write_reg(REG_ORIGIN_X, 20'h80000);
    write_reg(REG_ORIGIN_Y, 20'h80000);
    send_item(ANG_3Q + 16'd7, 16'sh8000, 16'sh7FFF);
    send_item(ANG_QUAD - 16'd3, 16'sd0, -16'sd1);
    drain_results();

    // Zero size collapses the corners along both axes.
    write_reg(REG_SPRITE_WIDTH, 20'hFF000);
    write_reg(REG_SPRITE_HEIGHT, 20'h00000);
    send_item(ANG_EIGHTH + 16'd3, 16'sd12, -16'sd34);
    send_item(ANG_HALF + ANG_EIGHTH, 16'sh7FFF, 16'sh8000);
    drain_results();

    // Writes to indexes past the last register must leave every register as it is.
    write_reg(REG_SPARE_6, 20'h00001);
    write_reg(REG_SPARE_7, 20'hFFFFF);
    send_item(ANG_QUAD + ANG_EIGHTH, 16'sd3, 16'sd3);
    drain_results();

    write_reg(REG_SPRITE_WIDTH, 20'h00001);
    write_reg(REG_SPRITE_HEIGHT, 20'h00001);
    write_reg(REG_ANCHOR_X, 20'h08000);
    write_reg(REG_ANCHOR_Y, 20'h08000);
    write_reg(REG_ORIGIN_X, 20'h00008);
    write_reg(REG_ORIGIN_Y, 20'hFFFF8);
    send_item(ANG_3Q + ANG_EIGHTH, -16'sd1, 16'sd1);
    drain_results();
  endtask

  task automatic test_random_settings;
    logic [CFG_DATA_W-1:0] data;
    logic [ANGLE_W-1:0] angle;
    logic signed [OFFSET_W-1:0] off_x, off_y;
    for (int phase = 0; phase < PHASES; phase++) begin
      req_steady = phase[0];
      rsp_steady = phase[1];
      for (int i = REG_SPRITE_WIDTH; i <= REG_ORIGIN_Y; i++) begin
        case ($urandom_range(0, 7))
          0: data = '0;
          1: data = '1;
          2: data = {1'b0, {(CFG_DATA_W - 1){1'b1}}};
          3: data = {1'b1, {(CFG_DATA_W - 1){1'b0}}};
          4: data = CFG_DATA_W'($urandom_range(1, 16));
          default: data = CFG_DATA_W'($urandom());
        endcase
        write_reg(CFG_INDEX_W'(i), data);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_6 : REG_SPARE_7,
                  CFG_DATA_W'($urandom()));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1: angle = ANGLE_W'($urandom());
          2: angle = ANGLE_W'(ANG_QUAD * $urandom_range(0, 4) + $urandom_range(0, 2) - 1);
          default: angle = ANGLE_W'($urandom_range(0, ANG_FULL - 1));
        endcase
        off_x = ($urandom_range(0, 3) == 0) ? OFFSET_W'(int'($urandom_range(0, 64)) - 32)
                                            : OFFSET_W'($urandom());
        off_y = ($urandom_range(0, 3) == 0) ? OFFSET_W'(int'($urandom_range(0, 64)) - 32)
                                            : OFFSET_W'($urandom());
        if (k == PHASE_ITEMS / 2 && (phase == 2 || $urandom_range(0, 2) == 0)) begin
          drain_results();
        end
        send_item(angle, off_x, off_y);
      end
      drain_results();
    end
    req_steady = 1'b0;
    rsp_steady = 1'b0;
  endtask

  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    forever begin
      gap = rsp_steady ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    corners_t got, want;
    logic [7:0][COORD_BITS-1:0] got_f, want_f;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.ul_x, rsp_ch.ul_y, rsp_ch.ur_x, rsp_ch.ur_y,
             rsp_ch.ll_x, rsp_ch.ll_y, rsp_ch.lr_x, rsp_ch.lr_y};
      if (expected_corners.size() == 0) begin
        report_mismatch($sformatf("result item with none expected: %h", got));
      end else begin
        want = expected_corners.pop_front();
        got_f = got;
        want_f = want;
        for (int i = 0; i < 8; i++) begin
          if (got_f[7 - i] !== want_f[7 - i]) begin
            report_mismatch($sformatf("%s got %0d expected %0d", field_names[i],
                                      $signed(got_f[7 - i]), $signed(want_f[7 - i])));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.angle    = '0;
    req_ch.offset_x = '0;
    req_ch.offset_y = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_settings();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
